### sv/twdirac_pkg.sv
// Shared types, geometry constants and fixed-point helpers for the twisted-mass Dirac core.
`timescale 1ns / 1ps
`default_nettype none

package twdirac_pkg;

  // Lattice geometry
  localparam int unsigned SITES     = 4096;
  localparam int unsigned SITE_W    = 12;
  localparam int unsigned SP_WORDS  = 24;
  localparam int unsigned GA_WORDS  = 72;
  localparam int unsigned NB_WORDS  = 8;
  localparam int unsigned SP_DEPTH  = SITES * SP_WORDS;
  localparam int unsigned GA_DEPTH  = SITES * GA_WORDS;
  localparam int unsigned NB_DEPTH  = SITES * NB_WORDS;
  localparam int unsigned SP_AW     = $clog2(SP_DEPTH);
  localparam int unsigned GA_AW     = $clog2(GA_DEPTH);
  localparam int unsigned NB_AW     = $clog2(NB_DEPTH);
  localparam int unsigned LAST_COMP = SP_WORDS - 1;

  // Configuration register indexes
  localparam logic [2:0] CFG_TWIST   = 3'd0;
  localparam logic [2:0] CFG_PHASE_T = 3'd1;
  localparam logic [2:0] CFG_PHASE_X = 3'd2;
  localparam logic [2:0] CFG_PHASE_Y = 3'd3;
  localparam logic [2:0] CFG_PHASE_Z = 3'd4;

  typedef enum logic [1:0] {
    MODE_SPINOR = 2'd0,
    MODE_GAUGE  = 2'd1,
    MODE_NBR    = 2'd2,
    MODE_RUN    = 2'd3
  } mode_e;

  // Spin-projection combine kinds: a+b, a-b, a+ib, a-ib
  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_SUB  = 2'd1,
    K_ADDI = 2'd2,
    K_SUBI = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TW_RD,
    S_TW_WB,
    S_NB_RD,
    S_PS_RD,
    S_PS_CMB,
    S_GA_RD,
    S_CHI_ACC,
    S_ACC_UPD,
    S_MUL,
    S_MUL_CMB,
    S_EMIT
  } state_e;

  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    if (v > $signed(34'h0_7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end else if (v < $signed(34'h3_8000_0000)) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] addsub(input logic [31:0] a, input logic [31:0] b,
                                         input logic sub);
    logic signed [33:0] ax;
    logic signed [33:0] bx;
    ax = $signed({{2{a[31]}}, a});
    bx = $signed({{2{b[31]}}, b});
    return sat34(sub ? (ax - bx) : (ax + bx));
  endfunction

  // Q1.30 x Q11.20, floor of product / 2^30, saturated
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return sat34($signed(p[63:30]));
  endfunction

  function automatic logic [31:0] comb_re(input kind_e k, input logic [31:0] ar,
                                          input logic [31:0] br, input logic [31:0] bi);
    logic [31:0] r;
    unique case (k)
      K_ADD:   r = addsub(ar, br, 1'b0);
      K_SUB:   r = addsub(ar, br, 1'b1);
      K_ADDI:  r = addsub(ar, bi, 1'b1);
      K_SUBI:  r = addsub(ar, bi, 1'b0);
      default: r = ar;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] comb_im(input kind_e k, input logic [31:0] ai,
                                          input logic [31:0] br, input logic [31:0] bi);
    logic [31:0] r;
    unique case (k)
      K_ADD:   r = addsub(ai, bi, 1'b0);
      K_SUB:   r = addsub(ai, bi, 1'b1);
      K_ADDI:  r = addsub(ai, br, 1'b0);
      K_SUBI:  r = addsub(ai, br, 1'b1);
      default: r = ai;
    endcase
    return r;
  endfunction

  // Partner spin for the projection of term t, half h
  function automatic logic [1:0] partner(input logic [2:0] t, input logic h);
    logic [1:0] p;
    case (t)
      3'd0, 3'd1, 3'd6, 3'd7: p = h ? 2'd3 : 2'd2;
      default:                p = h ? 2'd2 : 2'd3;
    endcase
    return p;
  endfunction

  function automatic kind_e kind_of(input logic [2:0] t, input logic h);
    kind_e k;
    case (t)
      3'd0:    k = K_ADD;
      3'd1:    k = K_SUB;
      3'd2:    k = K_ADDI;
      3'd3:    k = K_SUBI;
      3'd4:    k = h ? K_SUB : K_ADD;
      3'd5:    k = h ? K_ADD : K_SUB;
      3'd6:    k = h ? K_SUBI : K_ADDI;
      default: k = h ? K_ADDI : K_SUBI;
    endcase
    return k;
  endfunction

  function automatic kind_e conj_kind(input kind_e k);
    kind_e r;
    unique case (k)
      K_ADDI:  r = K_SUBI;
      K_SUBI:  r = K_ADDI;
      default: r = k;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/twisted_wilson_dirac_apply_core.sv
// Top level of the twisted-mass Wilson Dirac core: stores, sequencer and shared complex multiply.
`timescale 1ns / 1ps
`default_nettype none

// Twisted-mass Wilson Dirac operator, one site per run beat. Load beats (mode spinor, gauge or
// neighbour) write one word into the matching on-chip store; entries never
// written read back as whatever the RAM holds. A run beat names a site; the core applies
// (1 +/- i mu) to the site spinor, adds the eight hopping terms (projection, link or its
// adjoint, direction phase or its conjugate) and then sends the 24 result words in component
// order, last set on component 23. All arithmetic is 32-bit fixed point: products floor and
// saturate, every sum saturates. One 32x32 real multiplier does every product (four per
// complex product, 16 link-vector products of nine complex products plus phases per site) and
// each store delivers one word a cycle, so those set the length of a run. The input
// side stalls for the whole run; the last result beat sits in an output register so the next
// beat may be taken while it waits. Configuration writes are always ready and must only be
// issued while idle.
module twisted_wilson_dirac_apply_core
  import twdirac_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input beats
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [SITE_W-1:0]   site_i,
  input  wire logic [6:0]          slot_i,
  input  wire logic signed [31:0]  word_i,
  // result beats
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SITE_W-1:0]        out_site_o,
  output logic [4:0]               component_o,
  output logic signed [31:0]       result_value_o,
  output logic                     last_o,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [63:0]         cfg_data_i
);

  // ---------------------------------------------------------------- configuration
  logic [31:0] mu_q;
  logic [31:0] ph_re_q [4];
  logic [31:0] ph_im_q [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= '0;
      for (int i = 0; i < 4; i++) begin
        ph_re_q[i] <= '0;
        ph_im_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TWIST:   mu_q <= cfg_data_i[31:0];
        CFG_PHASE_T: begin
          ph_re_q[0] <= cfg_data_i[63:32];
          ph_im_q[0] <= cfg_data_i[31:0];
        end
        CFG_PHASE_X: begin
          ph_re_q[1] <= cfg_data_i[63:32];
          ph_im_q[1] <= cfg_data_i[31:0];
        end
        CFG_PHASE_Y: begin
          ph_re_q[2] <= cfg_data_i[63:32];
          ph_im_q[2] <= cfg_data_i[31:0];
        end
        CFG_PHASE_Z: begin
          ph_re_q[3] <= cfg_data_i[63:32];
          ph_im_q[3] <= cfg_data_i[31:0];
        end
        default: ; // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer state
  state_e            state_q, state_d;
  state_e            ret_q, ret_d;      // where the complex multiply hands back
  logic [SITE_W-1:0] site_q, site_d;
  logic [SITE_W-1:0] nb_q, nb_d;
  logic [2:0]        t_q, t_d;          // hopping term
  logic              h_q, h_d;          // spin half
  logic [1:0]        c_q, c_d;          // colour while projecting
  logic [1:0]        i_q, i_d;          // link row
  logic [1:0]        j_q, j_d;          // link column
  logic [1:0]        m_q, m_d;          // real product step
  logic [2:0]        q_q, q_d;          // read step
  logic [1:0]        u_q, u_d;          // accumulator update step
  logic [3:0]        tw_q, tw_d;        // twist complex index 0..11
  logic [4:0]        em_q, em_d;        // emit component
  logic              out_valid_q, out_valid_d;

  // datapath registers
  logic [31:0] a_re_q, a_re_d, a_im_q, a_im_d;   // Q1.30 factor
  logic [31:0] b_re_q, b_re_d, b_im_q, b_im_d;   // Q11.20 factor
  logic        cj_q, cj_d;
  logic [31:0] p_q [4];
  logic [31:0] p_d [4];
  logic [31:0] cres_re_q, cres_re_d, cres_im_q, cres_im_d;
  logic [31:0] x_q [4];
  logic [31:0] x_d [4];
  logic [31:0] psi_re_q [3];
  logic [31:0] psi_re_d [3];
  logic [31:0] psi_im_q [3];
  logic [31:0] psi_im_d [3];
  logic [31:0] chi_re_q, chi_re_d, chi_im_q, chi_im_d;
  logic [31:0] acc_q [SP_WORDS];
  logic [31:0] acc_d [SP_WORDS];
  logic [SITE_W-1:0] osite_q, osite_d;
  logic [4:0]        ocomp_q, ocomp_d;
  logic [31:0]       oval_q, oval_d;
  logic              olast_q, olast_d;

  // ---------------------------------------------------------------- stores
  logic [31:0]      sp_mem [SP_DEPTH];
  logic [31:0]      ga_mem [GA_DEPTH];
  logic [SITE_W-1:0] nb_mem [NB_DEPTH];

  logic             sp_we, ga_we, nb_we;
  logic [SP_AW-1:0] sp_wa, sp_ra;
  logic [GA_AW-1:0] ga_wa, ga_ra;
  logic [NB_AW-1:0] nb_wa, nb_ra;
  logic [31:0]      sp_rd_q, ga_rd_q;
  logic [SITE_W-1:0] nb_rd_q;

  always_ff @(posedge clk_i) begin
    if (sp_we) begin
      sp_mem[sp_wa] <= word_i;
    end
    sp_rd_q <= sp_mem[sp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ga_we) begin
      ga_mem[ga_wa] <= word_i;
    end
    ga_rd_q <= ga_mem[ga_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nb_we) begin
      nb_mem[nb_wa] <= word_i[SITE_W-1:0];
    end
    nb_rd_q <= nb_mem[nb_ra];
  end

  // ---------------------------------------------------------------- load decode
  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign sp_we = in_acc && (mode_e'(mode_i) == MODE_SPINOR) && (slot_i < 7'(SP_WORDS));
  assign ga_we = in_acc && (mode_e'(mode_i) == MODE_GAUGE) && (slot_i < 7'(GA_WORDS));
  assign nb_we = in_acc && (mode_e'(mode_i) == MODE_NBR) && (slot_i < 7'(NB_WORDS));
  assign sp_wa = SP_AW'(site_i) * SP_AW'(SP_WORDS) + SP_AW'(slot_i[4:0]);
  assign ga_wa = GA_AW'(site_i) * GA_AW'(GA_WORDS) + GA_AW'(slot_i);
  assign nb_wa = {site_i, slot_i[2:0]};

  // ---------------------------------------------------------------- read addressing
  logic [1:0]       dir;
  logic             bwd;
  kind_e            kind;
  logic [1:0]       pspin;
  logic [1:0]       psel;
  logic [4:0]       sp_off;
  logic [3:0]       gent;
  logic [SITE_W-1:0] lsite;

  assign dir   = t_q[2:1];
  assign bwd   = t_q[0];
  assign kind  = kind_of(t_q, h_q);
  assign pspin = partner(t_q, h_q);
  assign psel  = q_q[1] ? pspin : {1'b0, h_q};
  assign lsite = bwd ? nb_q : site_q;
  // backward terms read the adjoint: row and column swapped
  assign gent  = bwd ? (4'(j_q) * 4'd3 + 4'(i_q)) : (4'(i_q) * 4'd3 + 4'(j_q));

  always_comb begin
    sp_off = 5'(psel) * 5'd6 + 5'(c_q) * 5'd2 + 5'(q_q[0]);
    if (state_q == S_TW_RD) begin
      sp_ra = SP_AW'(site_q) * SP_AW'(SP_WORDS) + SP_AW'({tw_q, q_q[0]});
    end else begin
      sp_ra = SP_AW'(nb_q) * SP_AW'(SP_WORDS) + SP_AW'(sp_off);
    end
  end

  assign ga_ra = GA_AW'(lsite) * GA_AW'(GA_WORDS)
               + GA_AW'(7'(dir) * 7'd18 + 7'(gent) * 7'd2 + 7'(q_q[0]));
  assign nb_ra = {site_q, t_q};

  // accumulator read port: one address a cycle
  logic [4:0]  acc_ra;
  logic [31:0] acc_rd;
  logic [1:0]  uspin;
  kind_e       ukind;

  assign uspin  = u_q[1] ? pspin : {1'b0, h_q};
  assign ukind  = u_q[1] ? conj_kind(kind) : K_ADD;
  assign acc_ra = (state_q == S_EMIT) ? em_q
                                      : (5'(uspin) * 5'd6 + 5'(i_q) * 5'd2 + 5'(u_q[0]));
  assign acc_rd = acc_q[acc_ra];

  // shared real multiplier
  logic [31:0] mul_a, mul_b, mul_r;
  always_comb begin
    case (m_q)
      2'd0:    begin mul_a = a_re_q; mul_b = b_re_q; end
      2'd1:    begin mul_a = a_im_q; mul_b = b_im_q; end
      2'd2:    begin mul_a = a_re_q; mul_b = b_im_q; end
      default: begin mul_a = a_im_q; mul_b = b_re_q; end
    endcase
    mul_r = fmul(mul_a, mul_b);
  end

  // ---------------------------------------------------------------- next state and datapath
  logic [31:0] chi_re_n, chi_im_n;
  kind_e       tkind;
  logic        emit_go;

  assign chi_re_n = addsub(chi_re_q, cres_re_q, 1'b0);
  assign chi_im_n = addsub(chi_im_q, cres_im_q, 1'b0);
  assign tkind    = (tw_q >= 4'd6) ? K_SUB : K_ADD;   // lower spins take (1 - i mu)
  assign emit_go  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    site_d      = site_q;
    nb_d        = nb_q;
    t_d         = t_q;
    h_d         = h_q;
    c_d         = c_q;
    i_d         = i_q;
    j_d         = j_q;
    m_d         = m_q;
    q_d         = q_q;
    u_d         = u_q;
    tw_d        = tw_q;
    em_d        = em_q;
    out_valid_d = out_valid_q && out_stall_i;
    a_re_d      = a_re_q;
    a_im_d      = a_im_q;
    b_re_d      = b_re_q;
    b_im_d      = b_im_q;
    cj_d        = cj_q;
    p_d         = p_q;
    cres_re_d   = cres_re_q;
    cres_im_d   = cres_im_q;
    x_d         = x_q;
    psi_re_d    = psi_re_q;
    psi_im_d    = psi_im_q;
    chi_re_d    = chi_re_q;
    chi_im_d    = chi_im_q;
    acc_d       = acc_q;
    osite_d     = osite_q;
    ocomp_d     = ocomp_q;
    oval_d      = oval_q;
    olast_d     = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (mode_e'(mode_i) == MODE_RUN)) begin
          site_d  = site_i;
          tw_d    = '0;
          q_d     = '0;
          state_d = S_TW_RD;
        end
      end

      // twist: fetch s, then (i mu) s on the multiplier
      S_TW_RD: begin
        q_d = q_q + 3'd1;
        if (q_q == 3'd1) begin
          b_re_d = sp_rd_q;
        end
        if (q_q == 3'd2) begin
          b_im_d  = sp_rd_q;
          a_re_d  = '0;
          a_im_d  = mu_q;
          cj_d    = 1'b0;
          m_d     = '0;
          ret_d   = S_TW_WB;
          state_d = S_MUL;
        end
      end

      S_TW_WB: begin
        acc_d[{tw_q, 1'b0}] = comb_re(tkind, b_re_q, cres_re_q, cres_im_q);
        acc_d[{tw_q, 1'b1}] = comb_im(tkind, b_im_q, cres_re_q, cres_im_q);
        q_d = '0;
        if (tw_q == 4'd11) begin
          t_d     = '0;
          state_d = S_NB_RD;
        end else begin
          tw_d    = tw_q + 4'd1;
          state_d = S_TW_RD;
        end
      end

      S_NB_RD: begin
        q_d = q_q + 3'd1;
        if (q_q == 3'd1) begin
          nb_d    = nb_rd_q;
          h_d     = 1'b0;
          c_d     = '0;
          q_d     = '0;
          state_d = S_PS_RD;
        end
      end

      // projection: four words per colour, neighbour spin h then its partner
      S_PS_RD: begin
        q_d = q_q + 3'd1;
        if (q_q != 3'd0) begin
          x_d[q_q[1:0] - 2'd1] = sp_rd_q;
        end
        if (q_q == 3'd4) begin
          state_d = S_PS_CMB;
        end
      end

      S_PS_CMB: begin
        psi_re_d[c_q] = comb_re(kind, x_q[0], x_q[2], x_q[3]);
        psi_im_d[c_q] = comb_im(kind, x_q[1], x_q[2], x_q[3]);
        q_d = '0;
        if (c_q == 2'd2) begin
          i_d      = '0;
          j_d      = '0;
          chi_re_d = '0;
          chi_im_d = '0;
          state_d  = S_GA_RD;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = S_PS_RD;
        end
      end

      S_GA_RD: begin
        q_d = q_q + 3'd1;
        if (q_q == 3'd1) begin
          a_re_d = ga_rd_q;
        end
        if (q_q == 3'd2) begin
          a_im_d  = ga_rd_q;
          b_re_d  = psi_re_q[j_q];
          b_im_d  = psi_im_q[j_q];
          cj_d    = bwd;
          m_d     = '0;
          ret_d   = S_CHI_ACC;
          state_d = S_MUL;
        end
      end

      S_CHI_ACC: begin
        chi_re_d = chi_re_n;
        chi_im_d = chi_im_n;
        q_d      = '0;
        if (j_q == 2'd2) begin
          // row done: apply the direction phase
          a_re_d  = ph_re_q[dir];
          a_im_d  = ph_im_q[dir];
          b_re_d  = chi_re_n;
          b_im_d  = chi_im_n;
          cj_d    = bwd;
          m_d     = '0;
          u_d     = '0;
          ret_d   = S_ACC_UPD;
          state_d = S_MUL;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_GA_RD;
        end
      end

      S_ACC_UPD: begin
        acc_d[acc_ra] = u_q[0] ? comb_im(ukind, acc_rd, cres_re_q, cres_im_q)
                               : comb_re(ukind, acc_rd, cres_re_q, cres_im_q);
        u_d = u_q + 2'd1;
        if (u_q == 2'd3) begin
          q_d = '0;
          if (i_q != 2'd2) begin
            i_d      = i_q + 2'd1;
            j_d      = '0;
            chi_re_d = '0;
            chi_im_d = '0;
            state_d  = S_GA_RD;
          end else if (!h_q) begin
            h_d     = 1'b1;
            c_d     = '0;
            state_d = S_PS_RD;
          end else if (t_q == 3'd7) begin
            em_d    = '0;
            state_d = S_EMIT;
          end else begin
            t_d     = t_q + 3'd1;
            state_d = S_NB_RD;
          end
        end
      end

      S_MUL: begin
        p_d[m_q] = mul_r;
        m_d      = m_q + 2'd1;
        if (m_q == 2'd3) begin
          state_d = S_MUL_CMB;
        end
      end

      S_MUL_CMB: begin
        cres_re_d = addsub(p_q[0], p_q[1], !cj_q);
        cres_im_d = addsub(p_q[2], p_q[3], cj_q);
        state_d   = ret_q;
      end

      S_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          osite_d     = site_q;
          ocomp_d     = em_q;
          oval_d      = acc_rd;
          olast_d     = (em_q == 5'(LAST_COMP));
          em_d        = em_q + 5'd1;
          if (em_q == 5'(LAST_COMP)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      t_q         <= '0;
      h_q         <= 1'b0;
      c_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      m_q         <= '0;
      q_q         <= '0;
      u_q         <= '0;
      tw_q        <= '0;
      em_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      t_q         <= t_d;
      h_q         <= h_d;
      c_q         <= c_d;
      i_q         <= i_d;
      j_q         <= j_d;
      m_q         <= m_d;
      q_q         <= q_d;
      u_q         <= u_d;
      tw_q        <= tw_d;
      em_q        <= em_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    site_q    <= site_d;
    nb_q      <= nb_d;
    a_re_q    <= a_re_d;
    a_im_q    <= a_im_d;
    b_re_q    <= b_re_d;
    b_im_q    <= b_im_d;
    cj_q      <= cj_d;
    p_q       <= p_d;
    cres_re_q <= cres_re_d;
    cres_im_q <= cres_im_d;
    x_q       <= x_d;
    psi_re_q  <= psi_re_d;
    psi_im_q  <= psi_im_d;
    chi_re_q  <= chi_re_d;
    chi_im_q  <= chi_im_d;
    acc_q     <= acc_d;
    osite_q   <= osite_d;
    ocomp_q   <= ocomp_d;
    oval_q    <= oval_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_site_o     = osite_q;
  assign component_o    = ocomp_q;
  assign result_value_o = oval_q;
  assign last_o         = olast_q;

endmodule

`default_nettype wire

### sv/twdirac_checker.sv
// Port-level checker for the twisted-mass Dirac core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module twdirac_checker
  import twdirac_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic [1:0]        mode_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [4:0]        component_o,
  input wire logic [31:0]       result_value_o,
  input wire logic              last_o
);

  // last flag marks exactly the final component
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (component_o == 5'(LAST_COMP))))
    else $error("last flag does not match component");

  // a run beat keeps the input side stalled
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_e'(mode_i) == MODE_RUN)) |=> in_stall_o)
    else $error("input taken during a run");

  // early result beats leave the site still being sent
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && (component_o < 5'd22)) |=> in_stall_o)
    else $error("input side released before all results were sent");

  // a held result beat does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(result_value_o) && $stable(component_o)))
    else $error("stalled result beat changed");

endmodule

bind twisted_wilson_dirac_apply_core twdirac_checker u_twdirac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .mode_i         (mode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .component_o    (component_o),
  .result_value_o (result_value_o),
  .last_o         (last_o)
);

`default_nettype wire

### test/twisted_wilson_dirac_apply_core_test.sv
// Self-checking testbench for the twisted-mass Wilson Dirac core.
`timescale 1ns / 1ps

// Loads spinor, gauge and neighbour data for a small closed set of sites.
// Neighbour tables only point inside that set, so a run on any of those
// sites reads written entries only. Beats then mix runs on the set with
// reloads, loads to other sites and loads with out-of-range slots.
// An in-bench model predicts the 24 result beats of each run. The model
// follows the same fixed-point rules as the core: products floor after the
// shift by 30 and saturate, and every sum saturates.
// There are four idling phases. Each phase sets new register values while
// the core is idle, so the sender also pauses until every result is in.
module twisted_wilson_dirac_apply_core_test;
  import twdirac_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    mode_e       mode;
    logic [11:0] site;
    logic [6:0]  slot;
    logic [31:0] word;
  } beat_t;

  typedef struct packed {
    logic [11:0] site;
    logic [4:0]  comp;
    logic [31:0] value;
    logic        last;
  } result_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cplx_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          mode_i = '0;
  logic [11:0]         site_i = '0;
  logic [6:0]          slot_i = '0;
  logic signed [31:0]  word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [11:0]         out_site_o;
  logic [4:0]          component_o;
  logic signed [31:0]  result_value_o;
  logic                last_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [63:0]         cfg_data_i = '0;

  twisted_wilson_dirac_apply_core u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sites whose data is fully loaded. Their neighbours stay inside this set.
  logic [11:0] lattice_set[2] = '{12'd0, 12'd4095};

  beat_t   pending_beats[$];
  result_t awaited_results[$];
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;

  // Mirror of the core's stores and registers.
  logic signed [31:0] spinor_mem[int];
  logic signed [31:0] link_mem[int];
  logic [11:0]        nbr_mem[int];
  logic signed [31:0] mu_reg = '0;
  logic signed [31:0] phase_re[4] = '{default: '0};
  logic signed [31:0] phase_im[4] = '{default: '0};

  // Per hop term: partner spins and projection kinds for the two halves.
  logic [1:0] partner_spin[8][2] = '{'{2'd2, 2'd3}, '{2'd2, 2'd3}, '{2'd3, 2'd2},
    '{2'd3, 2'd2}, '{2'd3, 2'd2}, '{2'd3, 2'd2}, '{2'd2, 2'd3}, '{2'd2, 2'd3}};
  kind_e proj_kind[8][2] = '{'{K_ADD, K_ADD}, '{K_SUB, K_SUB}, '{K_ADDI, K_ADDI},
    '{K_SUBI, K_SUBI}, '{K_ADD, K_SUB}, '{K_SUB, K_ADD}, '{K_ADDI, K_SUBI},
    '{K_SUBI, K_ADDI}};

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q1.30 times Q11.20; the arithmetic shift floors.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 30);
  endfunction

  function automatic cplx_t cprod(input cplx_t a, input cplx_t b, input bit cj);
    cplx_t r;
    longint rr, ri;
    if (!cj) begin
      rr = longint'(qmul(a.re, b.re)) - qmul(a.im, b.im);
      ri = longint'(qmul(a.re, b.im)) + qmul(a.im, b.re);
    end else begin
      rr = longint'(qmul(a.re, b.re)) + qmul(a.im, b.im);
      ri = longint'(qmul(a.re, b.im)) - qmul(a.im, b.re);
    end
    r.re = clamp32(rr);
    r.im = clamp32(ri);
    return r;
  endfunction

  function automatic cplx_t combine(input kind_e k, input cplx_t a, input cplx_t b);
    cplx_t r;
    case (k)
      K_ADD: begin
        r.re = clamp32(longint'(a.re) + b.re);
        r.im = clamp32(longint'(a.im) + b.im);
      end
      K_SUB: begin
        r.re = clamp32(longint'(a.re) - b.re);
        r.im = clamp32(longint'(a.im) - b.im);
      end
      K_ADDI: begin
        r.re = clamp32(longint'(a.re) - b.im);
        r.im = clamp32(longint'(a.im) + b.re);
      end
      default: begin
        r.re = clamp32(longint'(a.re) + b.im);
        r.im = clamp32(longint'(a.im) - b.re);
      end
    endcase
    return r;
  endfunction

  function automatic kind_e flip_kind(input kind_e k);
    if (k == K_ADDI) return K_SUBI;
    if (k == K_SUBI) return K_ADDI;
    return k;
  endfunction

  function automatic cplx_t spinor_at(input int s, input int spin, input int col);
    cplx_t v;
    v.re = spinor_mem[s * 24 + spin * 6 + col * 2];
    v.im = spinor_mem[s * 24 + spin * 6 + col * 2 + 1];
    return v;
  endfunction

  function automatic cplx_t link_at(input int s, input int dir, input int row, input int col);
    cplx_t v;
    v.re = link_mem[s * 72 + dir * 18 + (row * 3 + col) * 2];
    v.im = link_mem[s * 72 + dir * 18 + (row * 3 + col) * 2 + 1];
    return v;
  endfunction

  // Applies one accepted beat to the mirror and queues the results it causes.
  function automatic void apply_dirac_beat(input beat_t b);
    cplx_t   acc[4][3];
    cplx_t   mu, ph, u, v;
    cplx_t   psi[3];
    cplx_t   chi[3];
    int      s, nb, ls, dir, p;
    bit      bwd;
    kind_e   k;
    result_t res;
    s = b.site;
    case (b.mode)
      MODE_SPINOR: if (b.slot < 24) spinor_mem[s * 24 + b.slot] = b.word;
      MODE_GAUGE:  if (b.slot < 72) link_mem[s * 72 + b.slot] = b.word;
      MODE_NBR:    if (b.slot < 8) nbr_mem[s * 8 + b.slot] = b.word[11:0];
      default: begin
        mu.re = '0;
        mu.im = mu_reg;
        for (int i = 0; i < 4; i++)
          for (int c = 0; c < 3; c++) begin
            v = spinor_at(s, i, c);
            acc[i][c] = combine(i < 2 ? K_ADD : K_SUB, v, cprod(mu, v, 1'b0));
          end
        for (int t = 0; t < 8; t++) begin
          dir = t >> 1;
          bwd = t[0];
          nb = nbr_mem[s * 8 + t] % SITES;
          ls = bwd ? nb : s;
          ph.re = phase_re[dir];
          ph.im = phase_im[dir];
          for (int h = 0; h < 2; h++) begin
            p = partner_spin[t][h];
            k = proj_kind[t][h];
            for (int c = 0; c < 3; c++)
              psi[c] = combine(k, spinor_at(nb, h, c), spinor_at(nb, p, c));
            for (int i = 0; i < 3; i++) begin
              chi[i].re = '0;
              chi[i].im = '0;
              for (int j = 0; j < 3; j++) begin
                // backward terms use the adjoint link: transpose plus conjugate
                u = bwd ? link_at(ls, dir, j, i) : link_at(ls, dir, i, j);
                chi[i] = combine(K_ADD, chi[i], cprod(u, psi[j], bwd));
              end
            end
            for (int c = 0; c < 3; c++) begin
              v = cprod(ph, chi[c], bwd);
              acc[h][c] = combine(K_ADD, acc[h][c], v);
              acc[p][c] = combine(flip_kind(k), acc[p][c], v);
            end
          end
        end
        for (int i = 0; i < 24; i++) begin
          v = acc[i / 6][(i % 6) / 2];
          res.site = b.site;
          res.comp = i[4:0];
          res.value = i[0] ? v.im : v.re;
          res.last = (i == 23);
          awaited_results.push_back(res);
        end
      end
    endcase
  endfunction

  // Fixed-point value: small, any 32-bit word, or a saturation extreme.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0, 1:    return 32'($signed($urandom_range(2 * (1 << 20))) - (1 << 20));
      2, 3:    return $urandom;
      4:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  function automatic void queue_beat(input mode_e m, input logic [11:0] s,
                                     input logic [6:0] sl, input logic [31:0] w);
    beat_t b;
    b.mode = m;
    b.site = s;
    b.slot = sl;
    b.word = w;
    pending_beats.push_back(b);
  endfunction

  // Neighbour word: junk in the upper bits, a member of the loaded set below.
  function automatic logic [31:0] pick_nbr();
    return {$urandom_range((1 << 20) - 1), 12'h0} | lattice_set[$urandom_range(1)];
  endfunction

  function automatic void queue_random_beats(input int n);
    logic [11:0] s;
    for (int i = 0; i < n; i++) begin
      s = lattice_set[$urandom_range(1)];
      case ($urandom_range(19))
        0, 1, 2, 3, 4:
          queue_beat(MODE_RUN, s, 7'($urandom), $urandom);
        5, 6, 7, 8:
          queue_beat(MODE_SPINOR, s, 7'($urandom_range(23)), pick_word());
        9, 10, 11, 12:
          queue_beat(MODE_GAUGE, s, 7'($urandom_range(71)), pick_word());
        13, 14:
          queue_beat(MODE_NBR, s, 7'($urandom_range(7)), pick_nbr());
        15, 16, 17:
          // sites outside the set: never run, never anyone's neighbour
          queue_beat(mode_e'($urandom_range(2)), 12'($urandom_range(4094, 1)),
                     7'($urandom), $urandom);
        default:
          // slot past the end of its store, dropped by the core
          queue_beat(mode_e'($urandom_range(2)), s, 7'($urandom_range(127, 72)),
                     $urandom);
      endcase
    end
  endfunction

  // Waits until every queued beat has been taken and every awaited result has
  // been received, so the core is idle with its output register empty.
  task automatic wait_quiet();
    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TWIST) begin
      mu_reg = data[31:0];
    end else begin
      phase_re[idx - 1] = data[63:32];
      phase_im[idx - 1] = data[31:0];
    end
  endtask

  task automatic write_all_regs(input logic [31:0] mu, input logic [63:0] ph[4]);
    write_reg(CFG_TWIST, {32'h0, mu});
    write_reg(CFG_PHASE_T, ph[0]);
    write_reg(CFG_PHASE_X, ph[1]);
    write_reg(CFG_PHASE_Y, ph[2]);
    write_reg(CFG_PHASE_Z, ph[3]);
  endtask

  // Input driver: a new beat goes out only once the previous one is gone.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        beat_t b;
        b = pending_beats.pop_front();
        in_valid_i <= 1'b1;
        mode_i     <= b.mode;
        site_i     <= b.site;
        slot_i     <= b.slot;
        word_i     <= b.word;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Monitor: prediction at input acceptance, comparison at result acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        beat_t b;
        b.mode = mode_e'(mode_i);
        b.site = site_i;
        b.slot = slot_i;
        b.word = word_i;
        apply_dirac_beat(b);
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing awaited: site %0d component %0d",
                 out_site_o, component_o);
          mismatches++;
        end else begin
          result_t e;
          e = awaited_results.pop_front();
          if (out_site_o !== e.site) begin
            $error("out_site: expected %0d, got %0d", e.site, out_site_o);
            mismatches++;
          end
          if (component_o !== e.comp) begin
            $error("component: expected %0d, got %0d", e.comp, component_o);
            mismatches++;
          end
          if (result_value_o !== e.value) begin
            $error("result_value: expected %0d, got %0d", $signed(e.value),
                   result_value_o);
            mismatches++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, last_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: nothing is accepted while a run is being computed, so the limit must cover a whole run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("twisted_wilson_dirac_apply_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    logic [63:0] ph[4];
    int          idle_tab[4] = '{0, 86, 0, 18};
    int          stall_tab[4] = '{0, 0, 86, 18};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = idle_tab[phase];
      receiver_stall_pct = stall_tab[phase];
      // Register sets: typical, all maximum, all minimum, random.
      case (phase)
        0: begin
          foreach (ph[d]) ph[d] = {32'h4000_0000, $urandom};
          write_all_regs(pick_word(), ph);
        end
        1: begin
          foreach (ph[d]) ph[d] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
          write_all_regs(32'h7FFF_FFFF, ph);
        end
        2: begin
          foreach (ph[d]) ph[d] = {32'h8000_0000, 32'h8000_0000};
          write_all_regs(32'h8000_0000, ph);
        end
        default: begin
          foreach (ph[d]) ph[d] = {$urandom, $urandom};
          write_all_regs($urandom, ph);
        end
      endcase

      if (phase == 0) begin
        // Fill every store entry that a run on the set can read.
        foreach (lattice_set[n]) begin
          for (int sl = 0; sl < 24; sl++)
            queue_beat(MODE_SPINOR, lattice_set[n], 7'(sl), pick_word());
          for (int sl = 0; sl < 72; sl++)
            queue_beat(MODE_GAUGE, lattice_set[n], 7'(sl), pick_word());
          for (int sl = 0; sl < 8; sl++)
            queue_beat(MODE_NBR, lattice_set[n], 7'(sl), pick_nbr());
        end
        // Directed: slots just past each store, and a run with every slot
        // and word bit set.
        queue_beat(MODE_SPINOR, 12'd0, 7'd24, 32'h7FFF_FFFF);
        queue_beat(MODE_SPINOR, 12'd4095, 7'd127, 32'h8000_0000);
        queue_beat(MODE_GAUGE, 12'd1, 7'd72, 32'hFFFF_FFFF);
        queue_beat(MODE_NBR, 12'd2, 7'd8, 32'h0000_0FFF);
        queue_beat(MODE_NBR, 12'd4095, 7'd127, 32'hFFFF_F123);
        queue_beat(MODE_RUN, 12'd4095, 7'h7F, 32'hFFFF_FFFF);
        // spin 0 of one site holding only extremes, so its sums saturate
        for (int sl = 0; sl < 6; sl++)
          queue_beat(MODE_SPINOR, 12'd0, 7'(sl), sl[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        queue_beat(MODE_RUN, 12'd0, 7'd0, 32'd0);
      end
      // every set site once per register set, then the random mix
      foreach (lattice_set[n]) queue_beat(MODE_RUN, lattice_set[n], 7'($urandom), $urandom);
      queue_random_beats(5);
      wait_quiet();
    end

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("twisted_wilson_dirac_apply_core_test OK");
    end else begin
      $display("twisted_wilson_dirac_apply_core_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
sv/twdirac_pkg.sv
sv/twisted_wilson_dirac_apply_core.sv
sv/twdirac_checker.sv
test/twisted_wilson_dirac_apply_core_test.sv
